@@ hw/rtl/rgbf_pkg.sv @@
// package with shared types and constants for the rgb 3x3 filter
`timescale 1ns / 1ps
`default_nettype none
package rgbf_pkg;

  localparam int MAX_SIDE   = 1024;
  localparam int POS_W      = $clog2(MAX_SIDE);
  localparam int SIDE_W     = POS_W + 1;
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;
  localparam int WIN_N      = 9;
  localparam int IDX_W      = 4;
  localparam int SUM_W      = 14;
  localparam int DVD_W      = 12;
  localparam int INT_W      = 10;
  localparam int MIN_SIDE   = 3;
  localparam int CENTER_WEIGHT = 9;
  localparam int CHANNEL_MAX   = 255;

  typedef enum logic [1:0] {
    REG_KERNEL = 2'd0,
    REG_DIVISOR = 2'd1,
    REG_EXTREMUM = 2'd2,
    REG_SIDE = 2'd3
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LINE,
    ST_DECIDE,
    ST_MINMAX,
    ST_XSUB,
    ST_DIVL,
    ST_DIV,
    ST_FIN,
    ST_EMIT_F,
    ST_EMIT_B
  } state_t;

  typedef struct packed {
    logic              kernel_mode;
    logic [CH_W-1:0]   divisor;
    logic              extremum_enable;
    logic [SIDE_W-1:0] side;
    logic              side_write;
  } cfg_t;

  typedef struct packed {
    logic             rd;
    logic             shift;
    logic             sum;
    logic             mm_step;
    logic [IDX_W-1:0] mm_idx;
    logic             xsub;
    logic             div_load;
    logic             div_step;
    logic             load_f;
    logic             load_b;
    logic             advance;
  } cmd_t;

  typedef struct packed {
    logic interior;
    logic border;
    logic ext_en;
  } status_t;

endpackage
`default_nettype wire

@@ hw/rtl/rgbf_if.sv @@
// word channel interfaces for pixels in and results out
`timescale 1ns / 1ps
`default_nettype none
interface rgbf_pix_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_red;
  logic [7:0] in_green;
  logic [7:0] in_blue;
  modport source (output valid, in_red, in_green, in_blue, input ready);
  modport sink (input valid, in_red, in_green, in_blue, output ready);
endinterface

interface rgbf_res_if;
  logic                       valid;
  logic                       ready;
  logic [rgbf_pkg::POS_W-1:0] out_row;
  logic [rgbf_pkg::POS_W-1:0] out_col;
  logic [7:0]                 out_red;
  logic [7:0]                 out_green;
  logic [7:0]                 out_blue;
  logic                       last_of_run;
  modport source (output valid, out_row, out_col, out_red, out_green, out_blue,
                  last_of_run, input ready);
  modport sink (input valid, out_row, out_col, out_red, out_green, out_blue,
                last_of_run, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/rgbf_regs.sv @@
// apb configuration registers
`timescale 1ns / 1ps
`default_nettype none
module rgbf_regs (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output rgbf_pkg::cfg_t   cfg
);
  logic                                kernel_mode;
  logic [rgbf_pkg::CH_W-1:0]           divisor;
  logic                                extremum_enable;
  logic [rgbf_pkg::SIDE_W-1:0]         image_side;
  logic                                wr;
  rgbf_pkg::reg_idx_t                  idx;

  assign pready = 1'b1;
  assign wr = psel & penable & pwrite;
  assign idx = rgbf_pkg::reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_mode <= 1'b0;
      divisor <= rgbf_pkg::CH_W'(9);
      extremum_enable <= 1'b0;
      image_side <= rgbf_pkg::SIDE_W'(rgbf_pkg::MAX_SIDE);
    end else if (wr) begin
      unique case (idx)
        rgbf_pkg::REG_KERNEL:   kernel_mode <= pwdata[0];
        rgbf_pkg::REG_DIVISOR:  divisor <= pwdata[rgbf_pkg::CH_W-1:0];
        rgbf_pkg::REG_EXTREMUM: extremum_enable <= pwdata[0];
        rgbf_pkg::REG_SIDE:     image_side <= pwdata[rgbf_pkg::SIDE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (idx)
      rgbf_pkg::REG_KERNEL:   prdata[0] = kernel_mode;
      rgbf_pkg::REG_DIVISOR:  prdata[rgbf_pkg::CH_W-1:0] = divisor;
      rgbf_pkg::REG_EXTREMUM: prdata[0] = extremum_enable;
      rgbf_pkg::REG_SIDE:     prdata[rgbf_pkg::SIDE_W-1:0] = image_side;
      default: ;
    endcase
  end

  always_comb begin
    cfg.kernel_mode = kernel_mode;
    cfg.divisor = (divisor == '0) ? rgbf_pkg::CH_W'(1) : divisor;
    cfg.extremum_enable = extremum_enable;
    if (image_side < rgbf_pkg::SIDE_W'(rgbf_pkg::MIN_SIDE))
      cfg.side = rgbf_pkg::SIDE_W'(rgbf_pkg::MIN_SIDE);
    else if (image_side > rgbf_pkg::SIDE_W'(rgbf_pkg::MAX_SIDE))
      cfg.side = rgbf_pkg::SIDE_W'(rgbf_pkg::MAX_SIDE);
    else
      cfg.side = image_side;
    cfg.side_write = wr && (idx == rgbf_pkg::REG_SIDE);
  end
endmodule
`default_nettype wire

@@ hw/rtl/rgbf_datapath.sv @@
// line stores, window, sums, extremum search, divider lanes and output register
`timescale 1ns / 1ps
`default_nettype none
module rgbf_datapath (
  input  wire logic           clk,
  input  wire logic           rst,
  input  rgbf_pkg::cfg_t      cfg,
  input  rgbf_pkg::cmd_t      cmd,
  output rgbf_pkg::status_t   status,
  rgbf_pix_if.sink            pixel,
  rgbf_res_if.source          result
);
  logic [rgbf_pkg::PIX_W-1:0] older_line [rgbf_pkg::MAX_SIDE];
  logic [rgbf_pkg::PIX_W-1:0] newer_line [rgbf_pkg::MAX_SIDE];
  logic [rgbf_pkg::PIX_W-1:0] older_rd;
  logic [rgbf_pkg::PIX_W-1:0] newer_rd;
  logic [rgbf_pkg::PIX_W-1:0] px;
  logic [rgbf_pkg::PIX_W-1:0] win [3][3];
  logic [rgbf_pkg::POS_W-1:0] row;
  logic [rgbf_pkg::POS_W-1:0] col;
  logic [rgbf_pkg::SIDE_W-1:0] row_inc;
  logic [rgbf_pkg::SIDE_W-1:0] col_inc;
  logic [rgbf_pkg::SIDE_W-1:0] side_m1;

  logic signed [rgbf_pkg::SUM_W-1:0] sum [3];
  logic signed [rgbf_pkg::SUM_W-1:0] sum_next [3];
  logic [rgbf_pkg::SUM_W-1:0]        all [3];
  logic [rgbf_pkg::SUM_W-1:0]        mid [3];

  logic [rgbf_pkg::PIX_W-1:0] pmin;
  logic [rgbf_pkg::PIX_W-1:0] pmax;
  logic [rgbf_pkg::INT_W-1:0] imin;
  logic [rgbf_pkg::INT_W-1:0] imax;
  logic [rgbf_pkg::PIX_W-1:0] msel;
  logic [rgbf_pkg::INT_W-1:0] mint;

  logic [rgbf_pkg::DVD_W-1:0] dvd [3];
  logic [rgbf_pkg::CH_W-1:0]  rem [3];
  logic [rgbf_pkg::CH_W:0]    rem_sh [3];
  logic                       ge [3];
  logic [rgbf_pkg::CH_W-1:0]  qclamp [3];

  always_ff @(posedge clk) begin
    if (cmd.rd) begin
      px <= {pixel.in_red, pixel.in_green, pixel.in_blue};
      older_rd <= older_line[col];
      newer_rd <= newer_line[col];
    end
    if (cmd.shift) begin
      older_line[col] <= newer_rd;
      newer_line[col] <= px;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          win[r][c] <= '0;
    end else if (cmd.shift) begin
      for (int r = 0; r < 3; r++) begin
        win[r][0] <= win[r][1];
        win[r][1] <= win[r][2];
      end
      win[0][2] <= older_rd;
      win[1][2] <= newer_rd;
      win[2][2] <= px;
    end
  end

  assign row_inc = {1'b0, row} + rgbf_pkg::SIDE_W'(1);
  assign col_inc = {1'b0, col} + rgbf_pkg::SIDE_W'(1);
  assign side_m1 = cfg.side - rgbf_pkg::SIDE_W'(1);

  always_ff @(posedge clk) begin
    if (rst || cfg.side_write) begin
      row <= '0;
      col <= '0;
    end else if (cmd.advance) begin
      if (col_inc >= cfg.side) begin
        col <= '0;
        row <= (row_inc >= cfg.side) ? '0 : row_inc[rgbf_pkg::POS_W-1:0];
      end else begin
        col <= col_inc[rgbf_pkg::POS_W-1:0];
      end
    end
  end

  always_comb begin
    status.interior = (row >= rgbf_pkg::POS_W'(2)) && (col >= rgbf_pkg::POS_W'(2));
    status.border = (row == '0) || (col == '0) || ({1'b0, row} == side_m1) ||
                    ({1'b0, col} == side_m1);
    status.ext_en = cfg.extremum_enable;
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      all[ch] = '0;
      for (int r = 0; r < 3; r++)
        for (int c = 0; c < 3; c++)
          all[ch] = all[ch] + rgbf_pkg::SUM_W'(win[r][c][(2-ch)*8 +: 8]);
      mid[ch] = rgbf_pkg::SUM_W'(win[1][1][(2-ch)*8 +: 8]);
      if (cfg.kernel_mode)
        sum_next[ch] = $signed(rgbf_pkg::SUM_W'(rgbf_pkg::CENTER_WEIGHT + 1) * mid[ch]
                       - all[ch]);
      else
        sum_next[ch] = $signed(all[ch]);
    end
  end

  // window scan in raster order
  always_comb begin
    unique case (cmd.mm_idx)
      4'd0: msel = win[0][0];
      4'd1: msel = win[0][1];
      4'd2: msel = win[0][2];
      4'd3: msel = win[1][0];
      4'd4: msel = win[1][1];
      4'd5: msel = win[1][2];
      4'd6: msel = win[2][0];
      4'd7: msel = win[2][1];
      default: msel = win[2][2];
    endcase
    mint = rgbf_pkg::INT_W'(msel[23:16]) + rgbf_pkg::INT_W'(msel[15:8]) +
           rgbf_pkg::INT_W'(msel[7:0]);
  end

  always_ff @(posedge clk) begin
    if (cmd.mm_step) begin
      if (cmd.mm_idx == '0 || mint <= imin) begin
        imin <= mint;
        pmin <= msel;
      end
      if (cmd.mm_idx == '0 || mint > imax) begin
        imax <= mint;
        pmax <= msel;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.sum)
        sum[ch] <= sum_next[ch];
      else if (cmd.xsub)
        sum[ch] <= sum[ch] - $signed(rgbf_pkg::SUM_W'(pmin[(2-ch)*8 +: 8]))
                           - $signed(rgbf_pkg::SUM_W'(pmax[(2-ch)*8 +: 8]));
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      rem_sh[ch] = {rem[ch], dvd[ch][rgbf_pkg::DVD_W-1]};
      ge[ch] = rem_sh[ch] >= {1'b0, cfg.divisor};
      qclamp[ch] = (dvd[ch][rgbf_pkg::DVD_W-1:rgbf_pkg::CH_W] != '0) ?
                   rgbf_pkg::CH_W'(rgbf_pkg::CHANNEL_MAX) : dvd[ch][rgbf_pkg::CH_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int ch = 0; ch < 3; ch++) begin
      if (cmd.div_load) begin
        rem[ch] <= '0;
        dvd[ch] <= sum[ch][rgbf_pkg::SUM_W-1] ? '0 : sum[ch][rgbf_pkg::DVD_W-1:0];
      end else if (cmd.div_step) begin
        rem[ch] <= ge[ch] ? rgbf_pkg::CH_W'(rem_sh[ch] - {1'b0, cfg.divisor})
                          : rem_sh[ch][rgbf_pkg::CH_W-1:0];
        dvd[ch] <= {dvd[ch][rgbf_pkg::DVD_W-2:0], ge[ch]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_f) begin
      result.out_row <= row - rgbf_pkg::POS_W'(1);
      result.out_col <= col - rgbf_pkg::POS_W'(1);
      result.out_red <= qclamp[0];
      result.out_green <= qclamp[1];
      result.out_blue <= qclamp[2];
      result.last_of_run <= ~status.border;
    end else if (cmd.load_b) begin
      result.out_row <= row;
      result.out_col <= col;
      result.out_red <= px[23:16];
      result.out_green <= px[15:8];
      result.out_blue <= px[7:0];
      result.last_of_run <= 1'b1;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/rgbf_ctrl.sv @@
// controller state machine sequencing one pixel at a time
`timescale 1ns / 1ps
`default_nettype none
module rgbf_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  rgbf_pkg::status_t  status,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  output rgbf_pkg::cmd_t     cmd
);
  rgbf_pkg::state_t             state;
  rgbf_pkg::state_t             state_next;
  logic [rgbf_pkg::IDX_W-1:0]   cnt;
  logic [rgbf_pkg::IDX_W-1:0]   cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rgbf_pkg::ST_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    cnt_next = cnt;
    cmd = '0;
    cmd.mm_idx = cnt;
    in_ready = 1'b0;
    out_valid = 1'b0;
    unique case (state)
      rgbf_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.rd = 1'b1;
          state_next = rgbf_pkg::ST_LINE;
        end
      end
      rgbf_pkg::ST_LINE: begin
        cmd.shift = 1'b1;
        state_next = rgbf_pkg::ST_DECIDE;
      end
      rgbf_pkg::ST_DECIDE: begin
        cmd.sum = 1'b1;
        cnt_next = '0;
        if (status.interior) begin
          state_next = status.ext_en ? rgbf_pkg::ST_MINMAX : rgbf_pkg::ST_DIVL;
        end else if (status.border) begin
          cmd.load_b = 1'b1;
          state_next = rgbf_pkg::ST_EMIT_B;
        end else begin
          cmd.advance = 1'b1;
          state_next = rgbf_pkg::ST_IDLE;
        end
      end
      rgbf_pkg::ST_MINMAX: begin
        cmd.mm_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == rgbf_pkg::IDX_W'(rgbf_pkg::WIN_N - 1))
          state_next = rgbf_pkg::ST_XSUB;
      end
      rgbf_pkg::ST_XSUB: begin
        cmd.xsub = 1'b1;
        state_next = rgbf_pkg::ST_DIVL;
      end
      rgbf_pkg::ST_DIVL: begin
        cmd.div_load = 1'b1;
        cnt_next = '0;
        state_next = rgbf_pkg::ST_DIV;
      end
      rgbf_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == rgbf_pkg::IDX_W'(rgbf_pkg::DVD_W - 1))
          state_next = rgbf_pkg::ST_FIN;
      end
      rgbf_pkg::ST_FIN: begin
        cmd.load_f = 1'b1;
        state_next = rgbf_pkg::ST_EMIT_F;
      end
      rgbf_pkg::ST_EMIT_F: begin
        out_valid = 1'b1;
        if (out_ready) begin
          if (status.border) begin
            cmd.load_b = 1'b1;
            state_next = rgbf_pkg::ST_EMIT_B;
          end else begin
            cmd.advance = 1'b1;
            state_next = rgbf_pkg::ST_IDLE;
          end
        end
      end
      rgbf_pkg::ST_EMIT_B: begin
        out_valid = 1'b1;
        if (out_ready) begin
          cmd.advance = 1'b1;
          state_next = rgbf_pkg::ST_IDLE;
        end
      end
      default: state_next = rgbf_pkg::ST_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/rgb_3x3_filter_with_extremum_removal.sv @@
// top level of the rgb 3x3 filter with extremum removal
// Pixels of a square frame enter in raster order, one word at a time; the block
// takes one pixel, finishes all of its result words, then takes the next. A pixel
// that produces no interior result passes the idle, line and decide states, plus
// one emit state per border word delivered. A pixel that completes an interior
// window also passes the nine-step extremum search over the window (with
// extremum removal on) and the 12-step shift-subtract divider shared by nothing
// else, one quotient bit per cycle for all three channels.
// Writing image_side restarts the frame at row 0, column 0.
`timescale 1ns / 1ps
`default_nettype none
module rgb_3x3_filter_with_extremum_removal (
  input  wire logic        clk,
  input  wire logic        rst,
  rgbf_pix_if.sink         pixel,
  rgbf_res_if.source       result,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  rgbf_pkg::cfg_t    cfg;
  rgbf_pkg::cmd_t    cmd;
  rgbf_pkg::status_t status;

  rgbf_regs u_regs (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
  );

  rgbf_ctrl u_ctrl (
    .clk(clk), .rst(rst), .status(status), .in_valid(pixel.valid),
    .in_ready(pixel.ready), .out_valid(result.valid), .out_ready(result.ready),
    .cmd(cmd)
  );

  rgbf_datapath u_dp (
    .clk(clk), .rst(rst), .cfg(cfg), .cmd(cmd), .status(status),
    .pixel(pixel), .result(result)
  );
endmodule
`default_nettype wire

@@ hw/rtl/rgbf_checker.sv @@
// port-level assertions for the rgb 3x3 filter
`timescale 1ns / 1ps
`default_nettype none
module rgbf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result word dropped");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("pixel taken while result pending");
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second pixel taken too soon");
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid) else $error("result valid after reset");
endmodule

bind rgb_3x3_filter_with_extremum_removal rgbf_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(pixel.valid), .in_ready(pixel.ready),
  .out_valid(result.valid), .out_ready(result.ready)
);
`default_nettype wire
